// File: src/ffbp_pkg.sv
`default_nettype none
package ffbp_pkg;

    localparam int POOL_DEPTH = 16;
    localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    localparam int DIM_W   = 13;
    localparam int ID_W    = 8;
    localparam int STAMP_W = 32;
    localparam int AGE_W   = 16;
    localparam int KIND_W  = 3;

    localparam logic [AGE_W-1:0] MAX_AGE_RESET = 16'd600;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_HIT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MISS    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EVICT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STORED  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DROPPED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd5;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [ID_W-1:0]    handle;
        logic [STAMP_W-1:0] stamp;
    } slot_t;

    typedef struct packed {
        logic             push;
        logic             remove;
        logic             clamp;
        logic [IDX_W-1:0] idx;
    } tbl_ctrl_t;

endpackage
`default_nettype wire

// File: src/ffbp_slot_table.sv
`default_nettype none
module ffbp_slot_table (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ffbp_pkg::tbl_ctrl_t          ctrl,
    input  wire ffbp_pkg::slot_t              wr_slot,
    input  wire logic [ffbp_pkg::STAMP_W-1:0] clamp_stamp,
    output ffbp_pkg::slot_t                   rd_slot,
    output logic [ffbp_pkg::CNT_W-1:0]        fill
);
    import ffbp_pkg::*;

    slot_t            slot_reg [POOL_DEPTH];
    logic [CNT_W-1:0] fill_reg;

    // Entries stay in release order; a removal shifts every younger entry down by one.
    for (genvar j = 0; j < POOL_DEPTH; j++) begin : g_slot
        if (j < POOL_DEPTH - 1) begin : g_mid
            always_ff @(posedge aclk) begin
                if (ctrl.push && fill_reg[IDX_W-1:0] == IDX_W'(j)) begin
                    slot_reg[j] <= wr_slot;
                end else if (ctrl.remove && ctrl.idx <= IDX_W'(j)) begin
                    slot_reg[j] <= slot_reg[j+1];
                end else if (ctrl.clamp && ctrl.idx == IDX_W'(j)) begin
                    slot_reg[j].stamp <= clamp_stamp;
                end
            end
        end else begin : g_top
            always_ff @(posedge aclk) begin
                if (ctrl.push && fill_reg[IDX_W-1:0] == IDX_W'(j)) begin
                    slot_reg[j] <= wr_slot;
                end else if (ctrl.clamp && ctrl.idx == IDX_W'(j)) begin
                    slot_reg[j].stamp <= clamp_stamp;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (ctrl.push) begin
            fill_reg <= fill_reg + CNT_W'(1);
        end else if (ctrl.remove) begin
            fill_reg <= fill_reg - CNT_W'(1);
        end
    end

    assign rd_slot = slot_reg[ctrl.idx];
    assign fill    = fill_reg;

endmodule
`default_nettype wire

// File: src/first_fit_buffer_pool_aging.sv
// Pool of returned image buffers with first-fit allocation and age eviction.
// Input items arrive on the s_axis channel: tuser[0] selects allocate (0) or
// free (1), tuser[1] says whether a freed item holds a buffer. Results leave
// on m_axis, one or more per input item; tlast marks the final one.
// A free item is answered with one result, registered in the cycle after it is accepted.
// An allocate item walks the pool from the oldest entry, one entry per cycle
// through a single compare and age unit while the output register is free: it
// produces a stale eviction for every expired entry passed, then a hit or a
// miss. s_axis_tready is low during a walk.
// A single output register holds each result; while the receiver stalls, the
// walk pauses on the current entry and no new input item is taken.
// max_age is written through cfg_wr_en/cfg_wr_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Synchronous active-low reset empties the pool, clears the output valid flag
// and restores max_age to 600; stored entries are not cleared.
`default_nettype none
module first_fit_buffer_pool_aging (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // [12:0] req_width, [25:13] req_height, [33:26] buffer_id,
    // [65:34] stamp, [97:66] now, [103:98] zero
    input  wire logic [103:0]                s_axis_tdata,
    // [0] command, [1] buffer_present
    input  wire logic [1:0]                  s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [7:0] out_id, [20:8] out_width, [33:21] out_height, [39:34] zero
    output logic [39:0]                      m_axis_tdata,
    // [2:0] kind
    output logic [2:0]                       m_axis_tuser,
    output logic                             m_axis_tlast,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ffbp_pkg::AGE_W-1:0]  cfg_wr_data
);
    import ffbp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [DIM_W-1:0]   req_w_reg, req_w_next;
    logic [DIM_W-1:0]   req_h_reg, req_h_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [AGE_W-1:0]   max_age_reg;

    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [DIM_W-1:0]   out_w_reg, out_w_next;
    logic [DIM_W-1:0]   out_h_reg, out_h_next;
    logic               out_last_reg, out_last_next;

    logic               in_command;
    logic               in_present;
    logic [DIM_W-1:0]   in_w;
    logic [DIM_W-1:0]   in_h;
    logic [ID_W-1:0]    in_id;
    logic [STAMP_W-1:0] in_stamp;
    logic [STAMP_W-1:0] in_now;

    tbl_ctrl_t          ctrl;
    slot_t              wr_slot;
    slot_t              rd_slot;
    logic [CNT_W-1:0]   fill;

    logic out_free;
    logic accept;
    logic fit;
    logic stale;

    assign in_command = s_axis_tuser[0];
    assign in_present = s_axis_tuser[1];
    assign in_w       = s_axis_tdata[12:0];
    assign in_h       = s_axis_tdata[25:13];
    assign in_id      = s_axis_tdata[33:26];
    assign in_stamp   = s_axis_tdata[65:34];
    assign in_now     = s_axis_tdata[97:66];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign wr_slot = '{width: in_w, height: in_h, handle: in_id, stamp: in_stamp};

    // A stamp ahead of now clamps to now, which leaves an age of zero and never evicts.
    assign fit   = (rd_slot.width >= req_w_reg) && (rd_slot.height >= req_h_reg);
    assign stale = (rd_slot.stamp <= now_reg) &&
                   ((now_reg - rd_slot.stamp) > {{(STAMP_W-AGE_W){1'b0}}, max_age_reg});

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        req_w_next     = req_w_reg;
        req_h_next     = req_h_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_id_next    = out_id_reg;
        out_w_next     = out_w_reg;
        out_h_next     = out_h_reg;
        out_last_next  = out_last_reg;
        ctrl           = '0;
        ctrl.idx       = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_command == CMD_ALLOC) begin
                        req_w_next = in_w;
                        req_h_next = in_h;
                        now_next   = in_now;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end else begin
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b1;
                        out_id_next    = in_id;
                        out_w_next     = in_w;
                        out_h_next     = in_h;
                        if (!in_present) begin
                            out_kind_next = KIND_IGNORED;
                            out_id_next   = '0;
                            out_w_next    = '0;
                            out_h_next    = '0;
                        end else if (fill >= CNT_W'(POOL_DEPTH)) begin
                            out_kind_next = KIND_DROPPED;
                        end else begin
                            out_kind_next = KIND_STORED;
                            ctrl.push     = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (idx_reg >= fill) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_MISS;
                        out_id_next    = '0;
                        out_w_next     = req_w_reg;
                        out_h_next     = req_h_reg;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end else if (fit || stale) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = fit ? KIND_HIT : KIND_EVICT;
                        out_id_next    = rd_slot.handle;
                        out_w_next     = rd_slot.width;
                        out_h_next     = rd_slot.height;
                        out_last_next  = fit;
                        ctrl.remove    = 1'b1;
                        if (fit) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        ctrl.clamp = rd_slot.stamp > now_reg;
                        idx_next   = idx_reg + CNT_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            max_age_reg   <= MAX_AGE_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                max_age_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        req_w_reg    <= req_w_next;
        req_h_reg    <= req_h_next;
        now_reg      <= now_next;
        out_kind_reg <= out_kind_next;
        out_id_reg   <= out_id_next;
        out_w_reg    <= out_w_next;
        out_h_reg    <= out_h_next;
        out_last_reg <= out_last_next;
    end

    ffbp_slot_table u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .wr_slot     (wr_slot),
        .clamp_stamp (now_reg),
        .rd_slot     (rd_slot),
        .fill        (fill)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_h_reg, out_w_reg, out_id_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import ffbp_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic               cmd;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [ID_W-1:0]    handle;
        logic               present;
        logic [STAMP_W-1:0] stamp;
        logic [STAMP_W-1:0] now;
    } pool_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   handle;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic              last;
    } pool_res_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [39:0]  m_axis_tdata;
    wire  [2:0]   m_axis_tuser;
    wire          m_axis_tlast;
    logic         cfg_wr_en = 1'b0;
    logic [AGE_W-1:0] cfg_wr_data = '0;

    first_fit_buffer_pool_aging u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    pool_req_t pending_reqs[$];
    pool_res_t expected_results[$];

    // Shadow copy of the pool, oldest entry at index 0.
    logic [DIM_W-1:0]   pool_width  [POOL_DEPTH];
    logic [DIM_W-1:0]   pool_height [POOL_DEPTH];
    logic [ID_W-1:0]    pool_handle [POOL_DEPTH];
    logic [STAMP_W-1:0] pool_stamp  [POOL_DEPTH];
    int                 pool_fill = 0;
    logic [AGE_W-1:0]   age_limit = MAX_AGE_RESET;

    int          fail_count = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;
    bit          item_loaded = 1'b0;
    pool_req_t   cur_item;
    int          send_gap = 0;
    int          sink_gap = 0;
    logic [31:0] version = 32'd5000;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic pool_remove(input int pos);
        for (int j = pos; j + 1 < pool_fill; j++) begin
            pool_width[j]  = pool_width[j + 1];
            pool_height[j] = pool_height[j + 1];
            pool_handle[j] = pool_handle[j + 1];
            pool_stamp[j]  = pool_stamp[j + 1];
        end
        pool_fill--;
    endtask

    task automatic push_result(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] handle,
                               input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                               input logic last);
        pool_res_t res;
        res.kind   = kind;
        res.handle = handle;
        res.width  = width;
        res.height = height;
        res.last   = last;
        expected_results.push_back(res);
    endtask

    // Applies one accepted item to the shadow pool and queues its results.
    task automatic pool_predict(input pool_req_t req);
        int i;
        if (req.cmd == CMD_ALLOC) begin
            i = 0;
            while (i < pool_fill) begin
                if (pool_width[i] >= req.width && pool_height[i] >= req.height) begin
                    push_result(KIND_HIT, pool_handle[i], pool_width[i], pool_height[i], 1'b1);
                    pool_remove(i);
                    return;
                end
                if (pool_stamp[i] > req.now)
                    pool_stamp[i] = req.now;
                if (req.now - pool_stamp[i] > {16'd0, age_limit}) begin
                    push_result(KIND_EVICT, pool_handle[i], pool_width[i], pool_height[i], 1'b0);
                    pool_remove(i);
                end else begin
                    i++;
                end
            end
            push_result(KIND_MISS, '0, req.width, req.height, 1'b1);
        end else if (!req.present) begin
            push_result(KIND_IGNORED, '0, '0, '0, 1'b1);
        end else if (pool_fill >= POOL_DEPTH) begin
            push_result(KIND_DROPPED, req.handle, req.width, req.height, 1'b1);
        end else begin
            pool_width[pool_fill]  = req.width;
            pool_height[pool_fill] = req.height;
            pool_handle[pool_fill] = req.handle;
            pool_stamp[pool_fill]  = req.stamp;
            pool_fill++;
            push_result(KIND_STORED, req.handle, req.width, req.height, 1'b1);
        end
    endtask

    task automatic post_request(input logic cmd, input logic [DIM_W-1:0] width,
                                input logic [DIM_W-1:0] height, input logic [ID_W-1:0] handle,
                                input logic present, input logic [STAMP_W-1:0] stamp,
                                input logic [STAMP_W-1:0] now);
        pool_req_t req;
        req.cmd     = cmd;
        req.width   = width;
        req.height  = height;
        req.handle  = handle;
        req.present = present;
        req.stamp   = stamp;
        req.now     = now;
        pending_reqs.push_back(req);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return DIM_W'($urandom_range(1, 8) * 64);
        else if (r < 95)
            return DIM_W'($urandom_range(1, 4096));
        return DIM_W'($urandom_range(0, 8191));
    endfunction

    // Mostly frees with stamps around the running version and allocates at that
    // version, so that the pool fills, ages out and gets hits.
    task automatic queue_traffic(input int count);
        logic [STAMP_W-1:0] stamp;
        int                 sel;
        repeat (count) begin
            if ($urandom_range(0, 99) < 55) begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    stamp = version - $urandom_range(0, 2 * age_limit + 2);
                else if (sel < 8)
                    stamp = version + $urandom_range(1, 2000);
                else if (sel == 8)
                    stamp = $urandom;
                else
                    stamp = version - $urandom_range(0, 100);
                post_request(CMD_FREE, pick_dim(), pick_dim(), ID_W'($urandom),
                             ($urandom_range(0, 11) != 0), stamp, $urandom);
            end else begin
                post_request(CMD_ALLOC, pick_dim(), pick_dim(), ID_W'($urandom),
                             1'($urandom), $urandom, version);
                if ($urandom_range(0, 19) == 0)
                    version = version + $urandom;
                else
                    version = version + $urandom_range(0, 400);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || item_loaded || expected_results.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_max_age(input logic [AGE_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        age_limit = value;
    endtask

    // Source side: holds each item until it is taken, then waits a random gap (none while steady is set).
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pool_predict(cur_item);
                item_loaded = 1'b0;
            end
            if (!item_loaded) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_item = pending_reqs.pop_front();
                    item_loaded = 1'b1;
                    s_axis_tdata <= {6'd0, cur_item.now, cur_item.stamp, cur_item.handle,
                                     cur_item.height, cur_item.width};
                    s_axis_tuser <= {cur_item.present, cur_item.cmd};
                    s_axis_tvalid <= 1'b1;
                    send_gap = steady ? 0 : gap_len();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: checks each taken item against the oldest expectation.
    always @(posedge aclk) begin
        pool_res_t want;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result item with nothing expected: kind %0d id %0d %0dx%0d",
                                 $realtime, m_axis_tuser, m_axis_tdata[7:0],
                                 m_axis_tdata[20:8], m_axis_tdata[33:21]);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.handle ||
                        m_axis_tdata[20:8] !== want.width ||
                        m_axis_tdata[33:21] !== want.height || m_axis_tlast !== want.last) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: expected kind %0d id %0d %0dx%0d last %0b, ",
                                      "got kind %0d id %0d %0dx%0d last %0b"},
                                     $realtime, want.kind, want.handle, want.width,
                                     want.height, want.last, m_axis_tuser, m_axis_tdata[7:0],
                                     m_axis_tdata[20:8], m_axis_tdata[33:21], m_axis_tlast);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    sink_gap = gap_len();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset value of max_age.
        post_request(CMD_ALLOC, 13'd0, 13'd0, 8'hFF, 1'b1, 32'hFFFF_FFFF, version);
        post_request(CMD_FREE, 13'd8191, 13'd8191, 8'd255, 1'b0, 32'hFFFF_FFFF, 32'd0);
        for (int i = 0; i < POOL_DEPTH; i++) begin
            post_request(CMD_FREE,
                         (i == 1) ? 13'd8191 : (i == 2) ? 13'd0 : DIM_W'(64 * (i + 1)),
                         (i == 1) ? 13'd8191 : (i == 3) ? 13'd4096 : DIM_W'(48 * (i + 1)),
                         (i == 0) ? 8'd0 : (i == 15) ? 8'd255 : ID_W'(i * 17), 1'b1,
                         (i % 3 == 0) ? version - 2000 :
                         (i % 3 == 1) ? version + 300 : version - 100,
                         32'hFFFF_FFFF);
        end
        // The pool is full now, so this one is dropped.
        post_request(CMD_FREE, 13'd4096, 13'd1, 8'hAA, 1'b1, version, 32'd0);
        post_request(CMD_ALLOC, 13'd500, 13'd500, 8'h55, 1'b0, 32'd0, version);
        post_request(CMD_ALLOC, 13'd0, 13'd0, 8'd0, 1'b1, 32'd7, version + 200);
        post_request(CMD_ALLOC, 13'd8191, 13'd8191, 8'd1, 1'b0, 32'd0, 32'hFFFF_FFFF);
        post_request(CMD_ALLOC, 13'd1, 13'd1, 8'd2, 1'b1, 32'hFFFF_FFFF, 32'd0);
        post_request(CMD_FREE, 13'd1, 13'd1, 8'd3, 1'b1, 32'd10, 32'd0);
        post_request(CMD_ALLOC, 13'd4096, 13'd4096, 8'd4, 1'b0, 32'd0, 32'd5);
        wait_idle();

        write_max_age(16'd0);
        queue_traffic(55);
        wait_idle();

        write_max_age(16'hFFFF);
        steady = 1'b1;
        queue_traffic(50);
        wait_idle();
        steady = 1'b0;

        write_max_age(AGE_W'($urandom_range(1, 4000)));
        version = 32'hFFFF_F000;
        queue_traffic(75);
        wait_idle();

        write_max_age(MAX_AGE_RESET);
        queue_traffic(70);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
